>>> rtl/cpr_pkg.sv
package cpr_pkg;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               first_point;
      logic               last_point;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               point_valid;
      logic               run_end;
      logic               curve_end;
      logic               truncated;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      OP_MAC,
      OP_SQRT,
      OP_DIV
   } arith_op_type;

   // iteration counts of the shared serial unit; the root takes the 66-bit
   // radicand two bits per step
   localparam logic [5:0] MAC_STEPS  = 6'd33;
   localparam logic [5:0] SQRT_STEPS = 6'd33;
   localparam logic [5:0] DIV_STEPS  = 6'd33;

   typedef struct packed {
      logic         start;
      arith_op_type op;
      logic         load;
      logic [65:0]  init;
      logic [32:0]  mcand;
      logic [32:0]  mplier;
      logic [33:0]  divisor;
   } arith_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [65:0] acc;
      logic [33:0] result;
   } arith_stat_type;

endpackage

>>> rtl/cpr_stream_if.sv
interface cpr_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/cpr_serial_unit.sv
// Shared bit-serial unit: multiply-accumulate, integer square root, division.
module cpr_serial_unit import cpr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  arith_cmd_type  cmd,
   output arith_stat_type stat
);

   logic         busy_ff;
   logic [5:0]   cnt_ff;
   arith_op_type op_ff;
   logic [65:0]  acc_ff;
   logic [65:0]  sh_ff;
   logic [32:0]  mp_ff;
   logic [36:0]  rem_ff;
   logic [33:0]  res_ff;
   logic [33:0]  div_ff;

   logic [36:0]  sq_shift;
   logic [36:0]  sq_trial;
   logic         sq_ge;
   logic [34:0]  dv_shift;
   logic         dv_ge;

   always_comb begin
      sq_shift = {rem_ff[34:0], acc_ff[65:64]};
      sq_trial = {1'b0, res_ff, 2'b01};
      sq_ge    = (sq_shift >= sq_trial);
      dv_shift = {rem_ff[33:0], acc_ff[32]};
      dv_ge    = (dv_shift >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.start && !busy_ff) begin
         busy_ff <= 1'b1;
         unique case (cmd.op)
            OP_MAC:  cnt_ff <= MAC_STEPS;
            OP_SQRT: cnt_ff <= SQRT_STEPS;
            OP_DIV:  cnt_ff <= DIV_STEPS;
            default: cnt_ff <= MAC_STEPS;
         endcase
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start && !busy_ff) begin
         op_ff  <= cmd.op;
         div_ff <= cmd.divisor;
         sh_ff  <= {33'b0, cmd.mcand};
         mp_ff  <= cmd.mplier;
         res_ff <= '0;
         if (cmd.load) begin
            acc_ff <= cmd.init;
         end
         // division starts from the numerator's top bits; quotient fits 33 bits
         if (cmd.op == OP_DIV) begin
            rem_ff <= {6'b0, acc_ff[63:33]};
         end else begin
            rem_ff <= '0;
         end
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MAC: begin
               if (mp_ff[0]) begin
                  acc_ff <= acc_ff + sh_ff;
               end
               sh_ff <= {sh_ff[64:0], 1'b0};
               mp_ff <= {1'b0, mp_ff[32:1]};
            end
            OP_SQRT: begin
               rem_ff <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
               res_ff <= {res_ff[32:0], sq_ge};
               acc_ff <= {acc_ff[63:0], 2'b00};
            end
            OP_DIV: begin
               rem_ff <= dv_ge ? {2'b0, dv_shift - {1'b0, div_ff}} : {2'b0, dv_shift};
               res_ff <= {res_ff[32:0], dv_ge};
               acc_ff <= {acc_ff[64:0], 1'b0};
            end
            default: begin
            end
         endcase
      end
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = busy_ff && (cnt_ff == 6'd1);
   assign stat.acc    = acc_ff;
   assign stat.result = res_ff;

endmodule

>>> rtl/closed_polyline_resampler.sv
// Sequence: a first point is out once the squared spacing is formed; a distance test is one
// multiply-accumulate per axis, and each emitted point adds a 33-step square root, then per
// axis a 33-step multiply and a 33-step divide, all on one shared bit-serial unit; a last
// point adds the closing run back to the start.
// Flow: one transaction at a time; a stalled output holds it.
// Reset (synchronous, active high): spacing 1.0, start and last point zero, output empty.
module closed_polyline_resampler import cpr_pkg::*; #(
   parameter int MAX_RUN = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   cpr_stream_if.sink           req_port,
   cpr_stream_if.source         rsp_port,
   input  logic                 csr_write_enable,
   input  logic [30:0]          csr_write_data
);

   localparam int CountWidth = $clog2(MAX_RUN + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SP2     = 4'd1;
   localparam logic [3:0] S_SPCAP   = 4'd2;
   localparam logic [3:0] S_SQ      = 4'd3;
   localparam logic [3:0] S_TEST    = 4'd4;
   localparam logic [3:0] S_EMIT    = 4'd5;
   localparam logic [3:0] S_ROOT    = 4'd6;
   localparam logic [3:0] S_DCAP    = 4'd7;
   localparam logic [3:0] S_MUL     = 4'd8;
   localparam logic [3:0] S_DIV     = 4'd9;
   localparam logic [3:0] S_STEP    = 4'd10;
   localparam logic [3:0] S_RUNDONE = 4'd11;
   localparam logic [3:0] S_FINAL   = 4'd12;

   logic [3:0]            state_ff;
   logic                  launched_ff;
   logic [30:0]           spacing_ff;
   logic [61:0]           sp2_ff;
   logic [33:0]           d_ff;
   logic signed [31:0]    start_x_ff, start_y_ff, start_z_ff;
   logic signed [31:0]    prev_x_ff, prev_y_ff, prev_z_ff;
   logic signed [31:0]    tgt_x_ff, tgt_y_ff, tgt_z_ff;
   logic                  first_ff, last_ff, closing_ff;
   logic                  pend_valid_ff, pend_trunc_ff;
   logic [CountWidth-1:0] count_ff;
   logic [1:0]            comp_ff;
   logic                  out_valid_ff;
   rsp_payload_type       out_ff;

   logic [30:0]           sp_eff;
   logic signed [32:0]    diff;
   logic signed [31:0]    cur_prev;
   logic [32:0]           mag;
   logic [32:0]           sum;
   logic                  out_free;
   logic                  out_load;
   logic                  far;
   arith_cmd_type         cmd;
   arith_stat_type        stat;

   cpr_serial_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // zero spacing behaves as the smallest step
   assign sp_eff   = (spacing_ff == '0) ? 31'd1 : spacing_ff;
   assign out_free = !out_valid_ff || rsp_port.ready;
   assign far      = (stat.acc >= {4'b0, sp2_ff});
   // the output register takes a new result this cycle
   assign out_load = out_free && ((state_ff == S_EMIT) ||
                                  ((state_ff == S_FINAL) && (pend_valid_ff || last_ff)));

   // per-axis difference toward the run's target
   always_comb begin
      unique case (comp_ff)
         2'd0: begin
            diff     = {tgt_x_ff[31], tgt_x_ff} - {prev_x_ff[31], prev_x_ff};
            cur_prev = prev_x_ff;
         end
         2'd1: begin
            diff     = {tgt_y_ff[31], tgt_y_ff} - {prev_y_ff[31], prev_y_ff};
            cur_prev = prev_y_ff;
         end
         default: begin
            diff     = {tgt_z_ff[31], tgt_z_ff} - {prev_z_ff[31], prev_z_ff};
            cur_prev = prev_z_ff;
         end
      endcase
      mag = diff[32] ? 33'(-diff) : 33'(diff);
      // step magnitude comes out of the divider; it takes the sign of the difference
      sum = diff[32] ? ({cur_prev[31], cur_prev} - stat.result[32:0])
                     : ({cur_prev[31], cur_prev} + stat.result[32:0]);
   end

   // drive the shared unit
   always_comb begin
      cmd         = '0;
      cmd.op      = OP_MAC;
      unique case (state_ff)
         S_SP2: begin
            cmd.start  = !launched_ff;
            cmd.load   = 1'b1;
            cmd.mcand  = {2'b0, sp_eff};
            cmd.mplier = {2'b0, sp_eff};
         end
         S_SQ: begin
            cmd.start  = !launched_ff;
            cmd.load   = (comp_ff == 2'd0);
            cmd.mcand  = mag;
            cmd.mplier = mag;
         end
         S_ROOT: begin
            cmd.start = !launched_ff;
            cmd.op    = OP_SQRT;
         end
         S_MUL: begin
            // preload half the distance so the divide rounds halves up
            cmd.start  = !launched_ff;
            cmd.load   = 1'b1;
            cmd.init   = {33'b0, d_ff[33:1]};
            cmd.mcand  = mag;
            cmd.mplier = {2'b0, sp_eff};
         end
         S_DIV: begin
            cmd.start   = !launched_ff;
            cmd.op      = OP_DIV;
            cmd.divisor = d_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= 31'd65536;
      end else if (csr_write_enable) begin
         spacing_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         launched_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_trunc_ff <= 1'b0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         start_z_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_z_ff     <= '0;
      end else begin
         // drain the output register when the sink takes it and nothing replaces it
         if (out_valid_ff && rsp_port.ready && !out_load) begin
            out_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_port.valid) begin
                  tgt_x_ff      <= req_port.payload.x;
                  tgt_y_ff      <= req_port.payload.y;
                  tgt_z_ff      <= req_port.payload.z;
                  first_ff      <= req_port.payload.first_point;
                  last_ff       <= req_port.payload.last_point;
                  closing_ff    <= 1'b0;
                  pend_valid_ff <= req_port.payload.first_point;
                  pend_trunc_ff <= 1'b0;
                  // a new curve: the point is both start and the pending result
                  if (req_port.payload.first_point) begin
                     start_x_ff <= req_port.payload.x;
                     start_y_ff <= req_port.payload.y;
                     start_z_ff <= req_port.payload.z;
                     prev_x_ff  <= req_port.payload.x;
                     prev_y_ff  <= req_port.payload.y;
                     prev_z_ff  <= req_port.payload.z;
                  end
                  state_ff <= S_SP2;
               end
            end

            S_SP2: begin
               if (!launched_ff) begin
                  launched_ff <= 1'b1;
               end else if (stat.done) begin
                  launched_ff <= 1'b0;
                  state_ff    <= S_SPCAP;
               end
            end

            S_SPCAP: begin
               sp2_ff <= stat.acc[61:0];
               if (first_ff) begin
                  state_ff <= S_RUNDONE;
               end else begin
                  count_ff <= '0;
                  comp_ff  <= 2'd0;
                  state_ff <= S_SQ;
               end
            end

            // accumulate the squared distance, one axis after another
            S_SQ: begin
               if (!launched_ff) begin
                  launched_ff <= 1'b1;
               end else if (stat.done) begin
                  launched_ff <= 1'b0;
                  if (comp_ff == 2'd2) begin
                     comp_ff  <= 2'd0;
                     state_ff <= S_TEST;
                  end else begin
                     comp_ff <= comp_ff + 2'd1;
                  end
               end
            end

            // emit only while the target is at least one spacing away and the run is under MAX_RUN points
            S_TEST: begin
               priority if (!far) begin
                  state_ff <= S_RUNDONE;
               end else if (count_ff == CountWidth'(MAX_RUN)) begin
                  pend_trunc_ff <= 1'b1;
                  state_ff      <= S_RUNDONE;
               end else if (pend_valid_ff) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_ROOT;
               end
            end

            // another point follows, so the pending one is not the run's last
            S_EMIT: begin
               if (out_free) begin
                  out_valid_ff        <= 1'b1;
                  out_ff.out_x        <= prev_x_ff;
                  out_ff.out_y        <= prev_y_ff;
                  out_ff.out_z        <= prev_z_ff;
                  out_ff.point_valid  <= 1'b1;
                  out_ff.run_end      <= 1'b0;
                  out_ff.curve_end    <= 1'b0;
                  out_ff.truncated    <= pend_trunc_ff;
                  pend_valid_ff       <= 1'b0;
                  state_ff            <= S_ROOT;
               end
            end

            S_ROOT: begin
               if (!launched_ff) begin
                  launched_ff <= 1'b1;
               end else if (stat.done) begin
                  launched_ff <= 1'b0;
                  state_ff    <= S_DCAP;
               end
            end

            S_DCAP: begin
               d_ff     <= stat.result;
               comp_ff  <= 2'd0;
               state_ff <= S_MUL;
            end

            S_MUL: begin
               if (!launched_ff) begin
                  launched_ff <= 1'b1;
               end else if (stat.done) begin
                  launched_ff <= 1'b0;
                  state_ff    <= S_DIV;
               end
            end

            S_DIV: begin
               if (!launched_ff) begin
                  launched_ff <= 1'b1;
               end else if (stat.done) begin
                  launched_ff <= 1'b0;
                  state_ff    <= S_STEP;
               end
            end

            // advance one axis; the axes do not depend on each other
            S_STEP: begin
               unique case (comp_ff)
                  2'd0:    prev_x_ff <= sum[31:0];
                  2'd1:    prev_y_ff <= sum[31:0];
                  default: prev_z_ff <= sum[31:0];
               endcase
               if (comp_ff == 2'd2) begin
                  pend_valid_ff <= 1'b1;
                  pend_trunc_ff <= 1'b0;
                  count_ff      <= count_ff + 1'b1;
                  comp_ff       <= 2'd0;
                  state_ff      <= S_SQ;
               end else begin
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end

            // after the last point, run back to the curve's start
            S_RUNDONE: begin
               if (last_ff && !closing_ff) begin
                  closing_ff <= 1'b1;
                  tgt_x_ff   <= start_x_ff;
                  tgt_y_ff   <= start_y_ff;
                  tgt_z_ff   <= start_z_ff;
                  count_ff   <= '0;
                  comp_ff    <= 2'd0;
                  state_ff   <= S_SQ;
               end else begin
                  state_ff <= S_FINAL;
               end
            end

            // close the transaction: pending point, bare marker, or nothing
            S_FINAL: begin
               if (pend_valid_ff || last_ff) begin
                  if (out_free) begin
                     out_valid_ff       <= 1'b1;
                     out_ff.out_x       <= pend_valid_ff ? prev_x_ff : '0;
                     out_ff.out_y       <= pend_valid_ff ? prev_y_ff : '0;
                     out_ff.out_z       <= pend_valid_ff ? prev_z_ff : '0;
                     out_ff.point_valid <= pend_valid_ff;
                     out_ff.run_end     <= 1'b1;
                     out_ff.curve_end   <= last_ff;
                     out_ff.truncated   <= pend_valid_ff && pend_trunc_ff;
                     pend_valid_ff      <= 1'b0;
                     state_ff           <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_port.ready   = (state_ff == S_IDLE);
   assign rsp_port.valid   = out_valid_ff;
   assign rsp_port.payload = out_ff;

endmodule
